[src/fvgn_pkg.sv]
// Shared constants, pipeline record types and constant tables for the
// fluid velocity and gaussian norm block. Depends on nothing.
package fvgn_pkg;

	// Number formats.
	localparam int FRAC_BITS     = 16;
	localparam int KERNEL_RADIUS = 4;
	localparam int WIN           = 2 * KERNEL_RADIUS + 1;
	localparam int VEL_W         = 22;
	localparam int NORM_W        = 24;
	localparam int GAUSS_W       = 17;
	localparam int ROW_W         = GAUSS_W + 4;
	localparam int SUM_W         = GAUSS_W + 7;
	localparam int DSR_W         = SUM_W;

	// Pipeline depths.
	localparam int SERIES_TERMS = 16;
	localparam int DECAY_STEPS  = 31;
	localparam int LANE_LAT     = 3 + 2 * SERIES_TERMS + DECAY_STEPS + 1;
	localparam int DIV_BITS     = 33;
	localparam int SIDE_DEPTH   = LANE_LAT + 2 + DIV_BITS;

	// Arithmetic constants.
	localparam int GRAVITY_LSB = ((1 << FRAC_BITS) + 50) / 100;
	localparam logic [31:0] EXP_NEG1_Q32 = 32'd1580030169;
	localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

	// Reciprocals ceil(2^38 / k) for exact truncating division by k = 1..16.
	localparam int RECIP_SHIFT = 38;
	localparam logic [38:0] RSH = 39'd1 << RECIP_SHIFT;
	localparam logic [38:0] RECIP_TAB [16] = '{
		(RSH + 39'd0) / 39'd1,   (RSH + 39'd1) / 39'd2,
		(RSH + 39'd2) / 39'd3,   (RSH + 39'd3) / 39'd4,
		(RSH + 39'd4) / 39'd5,   (RSH + 39'd5) / 39'd6,
		(RSH + 39'd6) / 39'd7,   (RSH + 39'd7) / 39'd8,
		(RSH + 39'd8) / 39'd9,   (RSH + 39'd9) / 39'd10,
		(RSH + 39'd10) / 39'd11, (RSH + 39'd11) / 39'd12,
		(RSH + 39'd12) / 39'd13, (RSH + 39'd13) / 39'd14,
		(RSH + 39'd14) / 39'd15, (RSH + 39'd15) / 39'd16
	};

	// Configuration register indexes.
	localparam logic [2:0] REG_FRAME_W = 3'd0;
	localparam logic [2:0] REG_FRAME_H = 3'd1;
	localparam logic [2:0] REG_WALL_LX = 3'd2;
	localparam logic [2:0] REG_WALL_LY = 3'd3;
	localparam logic [2:0] REG_WALL_HX = 3'd4;
	localparam logic [2:0] REG_WALL_HY = 3'd5;

	// Record handed along the Taylor series cells.
	typedef struct packed {
		logic [32:0]        term;
		logic signed [34:0] acc;
		logic [15:0]        f;
		logic [4:0]         n;
		logic               big;
	} series_t;

	// Record handed along the integer decay cells.
	typedef struct packed {
		logic [32:0] r;
		logic [4:0]  n;
		logic        big;
	} decay_t;

	// Record handed along the divider cells.
	typedef struct packed {
		logic [DSR_W-1:0]    rem;
		logic [DIV_BITS-1:0] num;
		logic [DIV_BITS-1:0] quo;
		logic [DSR_W-1:0]    dsr;
		logic                zero;
	} div_t;

endpackage

[src/fvgn_series_cell.sv]
// One Taylor series term of exp(-f): multiply by f, then divide by k.
// Depends on fvgn_pkg for the record type and the reciprocal table.
module fvgn_series_cell (
	input  logic              clk,
	input  logic              en,
	input  logic [3:0]        k_idx,
	input  fvgn_pkg::series_t din,
	output fvgn_pkg::series_t dout
);
	import fvgn_pkg::*;

	series_t     mul_s1;
	series_t     mul_c;
	series_t     out_c;
	logic [48:0] prod_a;
	logic [70:0] prod_b;
	logic [32:0] quot;

	// First stage: the term times the fraction, scaled back by 2^16.
	assign prod_a = 49'(din.term) * 49'(din.f);

	always_comb begin
		mul_c      = din;
		mul_c.term = {1'b0, prod_a[47:16]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s1 <= mul_c;
		end
	end

	// Second stage: exact truncating division by k through its reciprocal.
	assign prod_b = 71'(mul_s1.term[31:0]) * 71'(RECIP_TAB[k_idx]);
	assign quot   = prod_b[70:38];

	always_comb begin
		out_c      = mul_s1;
		out_c.term = quot;
		if (!k_idx[0]) begin
			out_c.acc = mul_s1.acc - $signed({2'b00, quot});
		end else begin
			out_c.acc = mul_s1.acc + $signed({2'b00, quot});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= out_c;
		end
	end

endmodule

[src/fvgn_decay_cell.sv]
// One step of the integer part of exp(-t): a rounded multiply by e^-1.
// Depends on fvgn_pkg for the record type and the constant.
module fvgn_decay_cell (
	input  logic             clk,
	input  logic             en,
	input  logic [4:0]       step,
	input  fvgn_pkg::decay_t din,
	output fvgn_pkg::decay_t dout
);
	import fvgn_pkg::*;

	logic [64:0] prod;
	decay_t      nxt_c;

	assign prod = 65'(din.r) * 65'(EXP_NEG1_Q32) + (65'd1 << 31);

	// The step only applies while its index is below the integer part.
	always_comb begin
		nxt_c = din;
		if (step < din.n) begin
			nxt_c.r = prod[64:32];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt_c;
		end
	end

endmodule

[src/fvgn_div_cell.sv]
// One quotient bit of the pipelined restoring divider for the norm.
// Depends on fvgn_pkg for the record type.
module fvgn_div_cell (
	input  logic           clk,
	input  logic           en,
	input  fvgn_pkg::div_t din,
	output fvgn_pkg::div_t dout
);
	import fvgn_pkg::*;

	logic [DSR_W:0] trial;
	logic           fits;
	div_t           nxt_c;

	assign trial = {din.rem, din.num[DIV_BITS-1]};
	assign fits  = trial >= {1'b0, din.dsr};

	always_comb begin
		nxt_c     = din;
		nxt_c.num = {din.num[DIV_BITS-2:0], 1'b0};
		nxt_c.quo = {din.quo[DIV_BITS-2:0], fits};
		if (fits) begin
			nxt_c.rem = DSR_W'(trial - {1'b0, din.dsr});
		end else begin
			nxt_c.rem = trial[DSR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt_c;
		end
	end

endmodule

[src/fvgn_lane.sv]
// One window position: squared distance, series and decay cell chains,
// rounding to Q.16. Depends on fvgn_pkg, fvgn_series_cell, fvgn_decay_cell.
module fvgn_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [4:0]             ofs_x,
	input  logic signed [4:0]             ofs_y,
	input  logic signed [fvgn_pkg::VEL_W-1:0] mx,
	input  logic signed [fvgn_pkg::VEL_W-1:0] my,
	output logic [fvgn_pkg::GAUSS_W-1:0]  g
);
	import fvgn_pkg::*;

	logic signed [22:0] dx, dy;
	logic [21:0]        ux_s1, uy_s1;
	logic [43:0]        sqx_s2, sqy_s2;
	logic [45:0]        e_rnd;
	series_t            start_s3;
	series_t            sw [SERIES_TERMS+1];
	decay_t             dw [DECAY_STEPS+1];
	logic [32:0]        g_rnd;

	// Distance from the window position to the velocity.
	assign dx = {{2{ofs_x[4]}}, ofs_x, 16'd0} - {mx[VEL_W-1], mx};
	assign dy = {{2{ofs_y[4]}}, ofs_y, 16'd0} - {my[VEL_W-1], my};

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1  <= dx[22] ? 22'(-dx) : dx[21:0];
			uy_s1  <= dy[22] ? 22'(-dy) : dy[21:0];
			sqx_s2 <= 44'(ux_s1) * 44'(ux_s1);
			sqy_s2 <= 44'(uy_s1) * 44'(uy_s1);
		end
	end

	// Round the squared distance to Q.16 and split it for the exponential.
	assign e_rnd = 46'(sqx_s2) + 46'(sqy_s2) + 46'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			start_s3.term <= 33'h1_0000_0000;
			start_s3.acc  <= 35'sh1_0000_0000;
			start_s3.f    <= e_rnd[31:16];
			start_s3.n    <= e_rnd[36:32];
			start_s3.big  <= |e_rnd[45:37];
		end
	end

	// Taylor series of the fraction part.
	assign sw[0] = start_s3;
	for (genvar gk = 0; gk < SERIES_TERMS; gk++) begin : g_series
		fvgn_series_cell u_cell (
			.clk   (clk),
			.en    (en),
			.k_idx (4'(gk)),
			.din   (sw[gk]),
			.dout  (sw[gk+1])
		);
	end

	// A negative sum is clamped to zero before the integer part.
	assign dw[0].r   = sw[SERIES_TERMS].acc[34] ? 33'd0 : sw[SERIES_TERMS].acc[32:0];
	assign dw[0].n   = sw[SERIES_TERMS].n;
	assign dw[0].big = sw[SERIES_TERMS].big;
	for (genvar gs = 0; gs < DECAY_STEPS; gs++) begin : g_decay
		fvgn_decay_cell u_cell (
			.clk  (clk),
			.en   (en),
			.step (5'(gs)),
			.din  (dw[gs]),
			.dout (dw[gs+1])
		);
	end

	// Round to Q.16; a large distance gives nothing.
	assign g_rnd = dw[DECAY_STEPS].r + 33'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			g <= dw[DECAY_STEPS].big ? '0 : g_rnd[32:16];
		end
	end

endmodule

[src/fluid_velocity_gaussian_norm.sv]
// Top level of the fluid velocity and gaussian norm block.
// Depends on fvgn_pkg, fvgn_lane and fvgn_div_cell.
//
// Usage: one pixel request per clock enters on pix_valid with its position,
// stored velocity and clear flag; it is taken when pix_valid is high and
// pix_stall is low. Results leave on res_valid and are taken when res_stall
// is low. Configuration writes (frame size, wall fractions) use cfg_valid
// and cfg_ready, which is always high; write only while the block is empty.
// Throughput is one pixel per clock while no result is stalled. The depth is
// set by the 81 window lanes, each a chain of 16 Taylor series cells of two
// stages and 31 decay cells, followed by a two stage adder tree and a 33 cell
// restoring divider.
// When the receiver stalls a waiting result, the whole pipeline holds and
// pix_stall rises in the same cycle. Reset clears all valid flags and loads
// the default frame size of 1920 by 1080 and walls at 0.05 and 0.95.
module fluid_velocity_gaussian_norm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  logic [11:0]                        pos_x,
	input  logic [11:0]                        pos_y,
	input  logic signed [fvgn_pkg::VEL_W-1:0]  vel_x,
	input  logic signed [fvgn_pkg::VEL_W-1:0]  vel_y,
	input  logic                               clear,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [fvgn_pkg::VEL_W-1:0]  new_vel_x,
	output logic signed [fvgn_pkg::VEL_W-1:0]  new_vel_y,
	output logic [fvgn_pkg::NORM_W-1:0]        norm,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [2:0]                         cfg_index,
	input  logic [15:0]                        cfg_data
);
	import fvgn_pkg::*;

	localparam logic signed [23:0] ONE  = 24'sd1 <<< FRAC_BITS;
	localparam logic signed [23:0] GRAV = 24'(GRAVITY_LSB);

	logic        en;
	logic [12:0] frame_w_q, frame_h_q;
	logic [15:0] wall_lx_q, wall_ly_q, wall_hx_q, wall_hy_q;

	logic [11:0]             px_s1, py_s1;
	logic signed [VEL_W-1:0] vx_s1, vy_s1, vx_s2, vy_s2, mx_s3, my_s3;
	logic                    clr_s1, clr_s2, clr_s3;
	logic                    v_s1, v_s2, v_s3;
	logic                    lo_x_s2, hi_x_s2, lo_y_s2, hi_y_s2;

	logic [28:0]       lhs_x, lhs_y;
	logic [29:0]       rlo_x, rhi_x, rlo_y, rhi_y;
	logic signed [23:0] sum_x, sum_y;

	logic [GAUSS_W-1:0] g_w [WIN][WIN];
	logic [ROW_W-1:0]   row_c [WIN];
	logic [ROW_W-1:0]   row_s1 [WIN];
	logic [SUM_W-1:0]   total_c;
	div_t               dv [DIV_BITS+1];

	logic signed [VEL_W-1:0] sd_mx [SIDE_DEPTH];
	logic signed [VEL_W-1:0] sd_my [SIDE_DEPTH];
	logic                    sd_clr [SIDE_DEPTH];
	logic [SIDE_DEPTH-1:0]   sd_v;

	// The pipeline moves whenever the output register is free or being taken.
	assign en        = !(res_valid && res_stall);
	assign pix_stall = res_valid && res_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= 13'd1920;
			frame_h_q <= 13'd1080;
			wall_lx_q <= 16'd3277;
			wall_ly_q <= 16'd3277;
			wall_hx_q <= 16'd62259;
			wall_hy_q <= 16'd62259;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_W: frame_w_q <= cfg_data[12:0];
				REG_FRAME_H: frame_h_q <= cfg_data[12:0];
				REG_WALL_LX: wall_lx_q <= cfg_data;
				REG_WALL_LY: wall_ly_q <= cfg_data;
				REG_WALL_HX: wall_hx_q <= cfg_data;
				REG_WALL_HY: wall_hy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid flags of the front stages and the delay line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			sd_v      <= '0;
			res_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= pix_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			sd_v      <= {sd_v[SIDE_DEPTH-2:0], v_s3};
			res_valid <= sd_v[SIDE_DEPTH-1];
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= pos_x;
			py_s1  <= pos_y;
			vx_s1  <= vel_x;
			vy_s1  <= vel_y;
			clr_s1 <= clear;
		end
	end

	// Wall tests: (2*pos + 1) * 2^16 against 2 * wall * size, exactly.
	assign lhs_x = {px_s1, 1'b1, 16'd0};
	assign lhs_y = {py_s1, 1'b1, 16'd0};
	assign rlo_x = {29'(wall_lx_q) * 29'(frame_w_q), 1'b0};
	assign rhi_x = {29'(wall_hx_q) * 29'(frame_w_q), 1'b0};
	assign rlo_y = {29'(wall_ly_q) * 29'(frame_h_q), 1'b0};
	assign rhi_y = {29'(wall_hy_q) * 29'(frame_h_q), 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			lo_x_s2 <= {1'b0, lhs_x} < rlo_x;
			hi_x_s2 <= {1'b0, lhs_x} > rhi_x;
			lo_y_s2 <= {1'b0, lhs_y} < rlo_y;
			hi_y_s2 <= {1'b0, lhs_y} > rhi_y;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
			clr_s2  <= clr_s1;
		end
	end

	// New velocity with gravity and wall pushes, saturated.
	always_comb begin
		sum_x = 24'(vx_s2);
		sum_y = 24'(vy_s2) - GRAV;
		if (lo_x_s2) sum_x = sum_x + ONE;
		if (hi_x_s2) sum_x = sum_x - ONE;
		if (lo_y_s2) sum_y = sum_y + ONE;
		if (hi_y_s2) sum_y = sum_y - ONE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum_x > 24'sd2097151) begin
				mx_s3 <= 22'sd2097151;
			end else if (sum_x < -24'sd2097152) begin
				mx_s3 <= -22'sd2097152;
			end else begin
				mx_s3 <= sum_x[VEL_W-1:0];
			end
			if (sum_y > 24'sd2097151) begin
				my_s3 <= 22'sd2097151;
			end else if (sum_y < -24'sd2097152) begin
				my_s3 <= -22'sd2097152;
			end else begin
				my_s3 <= sum_y[VEL_W-1:0];
			end
			clr_s3 <= clr_s2;
		end
	end

	// One lane per window position.
	for (genvar gi = 0; gi < WIN; gi++) begin : g_row
		for (genvar gj = 0; gj < WIN; gj++) begin : g_col
			fvgn_lane u_lane (
				.clk   (clk),
				.en    (en),
				.ofs_x (signed'(5'(gi - KERNEL_RADIUS))),
				.ofs_y (signed'(5'(gj - KERNEL_RADIUS))),
				.mx    (mx_s3),
				.my    (my_s3),
				.g     (g_w[gi][gj])
			);
		end
	end

	// Adder tree: row sums, then the window sum.
	always_comb begin
		for (int r = 0; r < WIN; r++) begin
			row_c[r] = '0;
			for (int c = 0; c < WIN; c++) begin
				row_c[r] = row_c[r] + ROW_W'(g_w[r][c]);
			end
		end
		total_c = '0;
		for (int r = 0; r < WIN; r++) begin
			total_c = total_c + SUM_W'(row_s1[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1    <= row_c;
			dv[0].rem  <= '0;
			dv[0].num  <= (DIV_BITS'(1) << (2 * FRAC_BITS)) + DIV_BITS'(total_c >> 1);
			dv[0].quo  <= '0;
			dv[0].dsr  <= total_c;
			dv[0].zero <= total_c == '0;
		end
	end

	// Restoring divider, one quotient bit per cell.
	for (genvar gd = 0; gd < DIV_BITS; gd++) begin : g_div
		fvgn_div_cell u_cell (
			.clk  (clk),
			.en   (en),
			.din  (dv[gd]),
			.dout (dv[gd+1])
		);
	end

	// Velocity and clear flag travel alongside the window computation.
	always_ff @(posedge clk) begin
		if (en) begin
			sd_mx[0]  <= mx_s3;
			sd_my[0]  <= my_s3;
			sd_clr[0] <= clr_s3;
			for (int d = 1; d < SIDE_DEPTH; d++) begin
				sd_mx[d]  <= sd_mx[d-1];
				sd_my[d]  <= sd_my[d-1];
				sd_clr[d] <= sd_clr[d-1];
			end
		end
	end

	// Output register: clear forces zeros, a zero window sum gives a norm of one, the norm saturates.
	always_ff @(posedge clk) begin
		if (en) begin
			if (sd_clr[SIDE_DEPTH-1]) begin
				new_vel_x <= '0;
				new_vel_y <= '0;
				norm      <= '0;
			end else begin
				new_vel_x <= sd_mx[SIDE_DEPTH-1];
				new_vel_y <= sd_my[SIDE_DEPTH-1];
				if (dv[DIV_BITS].zero) begin
					norm <= NORM_W'(1) << FRAC_BITS;
				end else if (dv[DIV_BITS].quo > DIV_BITS'(NORM_MAX)) begin
					norm <= NORM_MAX;
				end else begin
					norm <= dv[DIV_BITS].quo[NORM_W-1:0];
				end
			end
		end
	end

endmodule

[sim/fluid_velocity_gaussian_norm_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for fluid_velocity_gaussian_norm: random pixel requests
// under random idling on both sides, each result checked against a local predictor.
// Depends on fvgn_pkg and the block's RTL.
module fluid_velocity_gaussian_norm_tb;
	import fvgn_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 150;

	typedef struct {
		logic [11:0]             px;
		logic [11:0]             py;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic                    clr;
	} pixel_t;

	typedef struct {
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic [NORM_W-1:0]       nrm;
	} vel_norm_t;

	logic clk, arst_n;
	logic pix_valid, pix_stall, clear, res_valid, res_stall, cfg_valid, cfg_ready;
	logic [11:0] pos_x, pos_y;
	logic signed [VEL_W-1:0] vel_x, vel_y, new_vel_x, new_vel_y;
	logic [NORM_W-1:0] norm;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	// Mirror of the configuration registers.
	longint unsigned frame_w, frame_h, wall_lx, wall_ly, wall_hx, wall_hy;

	pixel_t    pix_q[$];
	vel_norm_t vel_norm_q[$];
	bit  pix_taken, quiet;
	int  fails, watchdog, n_pix, n_res, n_clear, n_cfg;

	fluid_velocity_gaussian_norm u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Wall push for one axis: +1 below the low wall, -1 beyond the high wall.
	function automatic longint wall_push(longint unsigned pos, longint unsigned size,
			longint unsigned lo, longint unsigned hi);
		longint unsigned lhs;
		longint w;
		lhs = ((2 * pos) + 1) << 16;
		w = 0;
		if (lhs < 2 * lo * size) w += 1;
		if (lhs > 2 * hi * size) w -= 1;
		return w;
	endfunction

	// exp(-t) with t and the result in Q.16, via a Taylor series and integer decay.
	function automatic longint unsigned gauss_q16(longint unsigned t);
		longint unsigned n, f, term, r;
		longint acc;
		n = t >> FRAC_BITS;
		if (n >= 32) return 0;
		f = (t & ((64'd1 << FRAC_BITS) - 1)) << (32 - FRAC_BITS);
		term = 64'd1 << 32;
		acc = longint'(term);
		for (int k = 1; k <= 16; k++) begin
			term = (term * f) >> 32;
			term = term / k;
			if (k % 2) acc -= longint'(term);
			else acc += longint'(term);
		end
		if (acc < 0) acc = 0;
		r = longint'(acc);
		for (int k = 0; k < n; k++)
			r = (r * 64'd1580030169 + (64'd1 << 31)) >> 32;
		return (r + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	endfunction

	function automatic longint sat_vel(longint v);
		if (v > 2097151) return 2097151;
		if (v < -2097152) return -2097152;
		return v;
	endfunction

	// New velocity after gravity and walls, and the reciprocal window sum.
	function automatic vel_norm_t predict_velocity_norm(pixel_t p);
		vel_norm_t r;
		longint mx, my, dx, dy;
		longint unsigned s, e, nrm;
		r = '{0, 0, 0};
		if (p.clr) return r;
		mx = sat_vel(longint'(p.vx) + 65536 * wall_push(p.px, frame_w, wall_lx, wall_hx));
		my = sat_vel(longint'(p.vy) - 655
			+ 65536 * wall_push(p.py, frame_h, wall_ly, wall_hy));
		s = 0;
		for (int i = -KERNEL_RADIUS; i <= KERNEL_RADIUS; i++)
			for (int j = -KERNEL_RADIUS; j <= KERNEL_RADIUS; j++) begin
				dx = i * 65536 - mx;
				dy = j * 65536 - my;
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				e = dx * dx + dy * dy;
				s += gauss_q16((e + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
			end
		nrm = (s == 0) ? (64'd1 << FRAC_BITS) : (((64'd1 << 32) + (s >> 1)) / s);
		if (nrm > 16777215) nrm = 16777215;
		r.vx = mx[VEL_W-1:0];
		r.vy = my[VEL_W-1:0];
		r.nrm = nrm[NORM_W-1:0];
		return r;
	endfunction

	// Sender side: hold a stalled request, otherwise idle at random or send the next.
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (!pix_valid || pix_taken) begin
			if (pix_q.size() != 0 && (quiet || $urandom_range(99) >= 32)) begin
				pixel_t p;
				p = pix_q.pop_front();
				pix_valid <= 1'b1;
				pos_x <= p.px;
				pos_y <= p.py;
				vel_x <= p.vx;
				vel_y <= p.vy;
				clear <= p.clr;
			end else begin
				pix_valid <= 1'b0;
			end
		end
		pix_taken = 1'b0;
		res_stall <= !quiet && ($urandom_range(99) < 32);
	end

	// Monitor: predict on each accepted request, check each accepted result.
	always @(posedge clk) begin
		bit moved;
		vel_norm_t want;
		moved = cfg_valid && cfg_ready;
		if (arst_n && pix_valid && !pix_stall) begin
			pixel_t p;
			p = '{pos_x, pos_y, vel_x, vel_y, clear};
			vel_norm_q.push_back(predict_velocity_norm(p));
			pix_taken = 1'b1;
			moved = 1'b1;
			n_pix++;
			if (clear) n_clear++;
		end
		if (arst_n && res_valid && !res_stall) begin
			moved = 1'b1;
			n_res++;
			if (vel_norm_q.size() == 0) begin
				$error("result with no request outstanding");
				fails++;
			end else begin
				want = vel_norm_q.pop_front();
				if (new_vel_x !== want.vx) begin
					$error("new_vel_x expected %0d got %0d", want.vx, new_vel_x);
					fails++;
				end
				if (new_vel_y !== want.vy) begin
					$error("new_vel_y expected %0d got %0d", want.vy, new_vel_y);
					fails++;
				end
				if (norm !== want.nrm) begin
					$error("norm expected %0d got %0d", want.nrm, norm);
					fails++;
				end
			end
		end
		watchdog = moved ? 0 : watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("fluid_velocity_gaussian_norm regression: fail");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FRAME_W: frame_w = val & 16'h1FFF;
			REG_FRAME_H: frame_h = val & 16'h1FFF;
			REG_WALL_LX: wall_lx = val;
			REG_WALL_LY: wall_ly = val;
			REG_WALL_HX: wall_hx = val;
			REG_WALL_HY: wall_hy = val;
			default: ;
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(int w, int h, int lx, int ly, int hx, int hy);
		write_reg(REG_FRAME_W, 16'(w));
		write_reg(REG_FRAME_H, 16'(h));
		write_reg(REG_WALL_LX, 16'(lx));
		write_reg(REG_WALL_LY, 16'(ly));
		write_reg(REG_WALL_HX, 16'(hx));
		write_reg(REG_WALL_HY, 16'(hy));
	endtask

	// Sender waits until every outstanding request has produced its result.
	task automatic drain();
		wait (pix_q.size() == 0 && !pix_valid && vel_norm_q.size() == 0);
		repeat (5) @(posedge clk);
	endtask

	task automatic add_pix(int x, int y, int vx, int vy, bit c);
		pixel_t p;
		p = '{12'(x), 12'(y), VEL_W'(vx), VEL_W'(vy), c};
		pix_q.push_back(p);
	endtask

	// Mostly small velocities, where the window sum is interesting, plus full range.
	task automatic add_random(int cnt, int fw, int fh);
		pixel_t p;
		for (int i = 0; i < cnt; i++) begin
			p.px = 12'((fw > 0 && $urandom_range(3) != 0) ? $urandom_range(fw - 1) : $urandom);
			p.py = 12'((fh > 0 && $urandom_range(3) != 0) ? $urandom_range(fh - 1) : $urandom);
			case ($urandom_range(3))
				0: begin p.vx = VEL_W'($urandom); p.vy = VEL_W'($urandom); end
				1: begin
					p.vx = VEL_W'($signed($urandom_range(1200000)) - 600000);
					p.vy = VEL_W'($signed($urandom_range(1200000)) - 600000);
				end
				default: begin
					p.vx = VEL_W'($signed($urandom_range(600000)) - 300000);
					p.vy = VEL_W'($signed($urandom_range(600000)) - 300000);
				end
			endcase
			p.clr = ($urandom_range(19) == 0);
			pix_q.push_back(p);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pix_valid = 1'b0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pos_x = '0;
		pos_y = '0;
		vel_x = '0;
		vel_y = '0;
		clear = 1'b0;
		quiet = 1'b0;
		frame_w = 1920;
		frame_h = 1080;
		wall_lx = 3277;
		wall_ly = 3277;
		wall_hx = 62259;
		wall_hy = 62259;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset configuration.
		add_pix(0, 0, 0, 0, 0);
		add_pix(4095, 4095, 0, 0, 0);
		add_pix(960, 540, 0, 0, 0);
		add_pix(960, 540, 2097151, 2097151, 0);
		add_pix(960, 540, -2097152, -2097152, 0);
		add_pix(0, 0, 2097151, 2097151, 0);
		add_pix(4095, 4095, -2097152, -2097152, 0);
		add_pix(4095, 0, -2097152, 2097151, 0);
		add_pix(1, 2, 65536, -65536, 0);
		add_pix(95, 53, 32768, 655, 0);
		add_pix(96, 54, -32768, 0, 0);
		add_pix(1823, 1025, 131072, -131072, 0);
		add_pix(1824, 1026, 300000, -300000, 0);
		add_pix(500, 500, 2097151, -2097152, 1);
		add_pix(4095, 4095, -1, -1, 1);
		add_pix(100, 100, 1, 1, 0);
		add_pix(100, 100, 400000, 400000, 0);
		add_random(280, 1920, 1080);
		drain();

		// Smallest and largest frame, walls at the extremes, no idling at all.
		quiet = 1'b1;
		setup(1, 4096, 0, 0, 65535, 65535);
		add_pix(0, 0, 0, 0, 0);
		add_pix(4095, 4095, 0, 0, 0);
		add_random(300, 1, 4096);
		drain();
		quiet = 1'b0;

		// Every pixel outside both x walls at once; in y only row 0 is below the low wall.
		setup(4096, 1, 65535, 65535, 0, 0);
		add_pix(0, 0, 2097151, 2097151, 0);
		add_pix(4095, 4095, -2097152, -2097152, 0);
		add_random(300, 4096, 1);
		drain();

		// Zero frame size behaves as an infinite position.
		setup(0, 0, 3277, 3277, 62259, 62259);
		add_pix(0, 0, 0, 0, 0);
		add_random(150, 0, 0);
		drain();

		// Random configurations.
		for (int ph = 0; ph < 5; ph++) begin
			int w, h;
			w = $urandom_range(4096, 1);
			h = $urandom_range(4096, 1);
			setup(w, h, $urandom_range(65535), $urandom_range(65535),
				$urandom_range(65535), $urandom_range(65535));
			add_random(110, w, h);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (vel_norm_q.size() != 0) begin
			$error("%0d results never arrived", vel_norm_q.size());
			fails++;
		end
		$display("Covered %0d pixel requests (%0d cleared) and %0d results over nine",
			n_pix, n_clear, n_res);
		$display("configurations (%0d register writes), including zero and extreme sizes.",
			n_cfg);
		if (fails == 0)
			$display("fluid_velocity_gaussian_norm regression: pass");
		else
			$display("fluid_velocity_gaussian_norm regression: fail");
		$finish;
	end
endmodule
